FILE: sv/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants of the LFU cache table: request and response
// payloads, the entry record, the sequencer states and register defaults.
// ----------------------------------------------------------------------------
package lct_pkg;

   localparam int DEF_ENTRIES = 16;
   localparam int CAP_W       = 5;
   localparam int KEY_W       = 32;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 32;

   localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_NEW = 32'd1;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_STORE  = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic [KEY_W-1:0]         key;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } rsp_type;

   // one table entry, used for the read port and the slot write port
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SWEEP
   } state_type;

endpackage

FILE: sv/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table
// Fully associative key/value table with least-frequently-used replacement
// and least-recently-used tie break.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_item: mode, key, value) transfers at a rising edge where
//   start is high and busy is low. busy stays high until the request is done.
//   Mode lookup returns the stored value on a hit; mode store writes the value,
//   evicting the lowest-count, least recent entry when the table is full.
//   One response per request appears on rsp_item for exactly one cycle with
//   rsp_strobe high; it cannot be held off by the receiver.
//   The response comes after one scan pass over all entries through the shared
//   compare unit, one entry per cycle through the registered memory read port.
//   Requests that change the table then run a rank update pass over the same
//   read port; a new request can transfer only after that pass is done.
//   csr_we/csr_wdata write the capacity register (reset 16); the user must do
//   so only while idle, as the block itself does not enforce it.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
   parameter int ENTRIES = lct_pkg::DEF_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  lct_pkg::req_type            req_item,
   output logic                        rsp_strobe,
   output lct_pkg::rsp_type            rsp_item,
   input  logic                        csr_we,
   input  logic [lct_pkg::CAP_W-1:0]   csr_wdata
);

   localparam int IDX_W  = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = OCC_W > lct_pkg::CAP_W ? OCC_W : lct_pkg::CAP_W;

   lct_pkg::state_type            state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   lct_pkg::req_type              req_ff;
   logic [lct_pkg::CAP_W-1:0]     capacity_ff;
   logic [OCC_W-1:0]              occ_ff, occ_in;
   logic [IDX_W-1:0]              sel_ff, sel_in;
   logic [IDX_W-1:0]              thr_ff, thr_in;
   logic                          thr_all_ff, thr_all_in;

   logic                          accept;
   logic                          last;
   logic [IDX_W-1:0]              proc_idx;
   logic [IDX_W-1:0]              rd_addr;
   lct_pkg::slot_type             rd_entry;
   logic [IDX_W-1:0]              rd_rank;
   logic                          slot_we;
   lct_pkg::slot_type             slot_wr;
   logic [IDX_W-1:0]              slot_addr;
   logic                          rank_we;
   logic [IDX_W-1:0]              rank_wdata;
   logic                          scan_step;

   logic                          found;
   logic [IDX_W-1:0]              match_idx;
   logic [lct_pkg::DATA_W-1:0]    match_data;
   logic [lct_pkg::COUNT_W-1:0]   match_count;
   logic [IDX_W-1:0]              match_rank;
   logic [IDX_W-1:0]              vic_idx;
   logic [IDX_W-1:0]              vic_rank;
   logic [IDX_W-1:0]              free_idx;

   logic [CMP_W-1:0]              cap_ext;
   logic [CMP_W-1:0]              cap_eff;
   logic                          do_hit;
   logic                          do_insert;
   logic                          table_full;
   logic                          update;

   assign accept   = start && !busy;
   assign last     = (cnt_ff == CNT_W'(ENTRIES));
   assign proc_idx = IDX_W'(cnt_ff - CNT_W'(1));

   // capacity above the table size acts as the table size
   assign cap_ext    = CMP_W'(capacity_ff);
   assign cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
   assign table_full = (CMP_W'(occ_ff) >= cap_eff);
   assign do_hit     = found && ((req_ff.mode == lct_pkg::MODE_LOOKUP) ||
                                 (cap_eff != '0));
   assign do_insert  = !found && (req_ff.mode == lct_pkg::MODE_STORE) &&
                       (cap_eff != '0);
   assign update     = do_hit || do_insert;

   lct_entry_ram #(
      .ENTRIES    (ENTRIES)
   ) u_ram (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (rd_addr),
      .rd_entry   (rd_entry),
      .rd_rank    (rd_rank),
      .slot_we    (slot_we),
      .slot_addr  (slot_addr),
      .slot_wr    (slot_wr),
      .rank_we    (rank_we),
      .rank_addr  (proc_idx),
      .rank_wdata (rank_wdata)
   );

   lct_scan #(
      .ENTRIES     (ENTRIES)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (accept),
      .step        (scan_step),
      .idx         (proc_idx),
      .entry       (rd_entry),
      .rank        (rd_rank),
      .key         (req_ff.key),
      .found       (found),
      .match_idx   (match_idx),
      .match_data  (match_data),
      .match_count (match_count),
      .match_rank  (match_rank),
      .vic_idx     (vic_idx),
      .vic_rank    (vic_rank),
      .free_idx    (free_idx)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lct_pkg::ST_IDLE: begin
            if (start) state_in = lct_pkg::ST_SCAN;
         end
         lct_pkg::ST_SCAN: begin
            if (last) state_in = lct_pkg::ST_DECIDE;
         end
         lct_pkg::ST_DECIDE: begin
            state_in = update ? lct_pkg::ST_SWEEP : lct_pkg::ST_IDLE;
         end
         lct_pkg::ST_SWEEP: begin
            if (last) state_in = lct_pkg::ST_IDLE;
         end
         default: begin
            state_in = lct_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      busy       = 1'b1;
      cnt_in     = '0;
      rd_addr    = '0;
      scan_step  = 1'b0;
      rsp_strobe = 1'b0;
      rsp_item   = '0;
      slot_we    = 1'b0;
      slot_addr  = match_idx;
      slot_wr    = '0;
      rank_we    = 1'b0;
      rank_wdata = '0;
      occ_in     = occ_ff;
      sel_in     = sel_ff;
      thr_in     = thr_ff;
      thr_all_in = thr_all_ff;
      case (state_ff)
         lct_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         lct_pkg::ST_SCAN: begin
            cnt_in    = last ? '0 : cnt_ff + CNT_W'(1);
            rd_addr   = last ? '0 : IDX_W'(cnt_ff);
            scan_step = (cnt_ff != '0);
         end
         lct_pkg::ST_DECIDE: begin
            rsp_strobe        = 1'b1;
            rsp_item.hit      = found;
            rsp_item.read_value = (found && req_ff.mode == lct_pkg::MODE_LOOKUP) ?
                                  match_data : '0;
            slot_wr.valid     = 1'b1;
            slot_wr.key       = req_ff.key;
            if (do_hit) begin
               slot_we       = 1'b1;
               slot_addr     = match_idx;
               slot_wr.data  = (req_ff.mode == lct_pkg::MODE_STORE) ?
                               req_ff.value : match_data;
               slot_wr.count = (match_count == lct_pkg::COUNT_MAX) ?
                               match_count : match_count + lct_pkg::COUNT_NEW;
               sel_in        = match_idx;
               thr_in        = match_rank;
               thr_all_in    = 1'b0;
            end else if (do_insert) begin
               slot_we       = 1'b1;
               slot_wr.data  = req_ff.value;
               slot_wr.count = lct_pkg::COUNT_NEW;
               if (table_full) begin
                  // victim's slot is reused: same rank shift as a promote
                  slot_addr  = vic_idx;
                  sel_in     = vic_idx;
                  thr_in     = vic_rank;
                  thr_all_in = 1'b0;
               end else begin
                  slot_addr  = free_idx;
                  sel_in     = free_idx;
                  thr_all_in = 1'b1;
                  occ_in     = occ_ff + OCC_W'(1);
               end
            end
         end
         lct_pkg::ST_SWEEP: begin
            cnt_in  = last ? '0 : cnt_ff + CNT_W'(1);
            rd_addr = last ? '0 : IDX_W'(cnt_ff);
            if (cnt_ff != '0) begin
               if (proc_idx == sel_ff) begin
                  rank_we    = 1'b1;
                  rank_wdata = '0;
               end else if (rd_entry.valid && (thr_all_ff || rd_rank < thr_ff)) begin
                  rank_we    = 1'b1;
                  rank_wdata = rd_rank + IDX_W'(1);
               end
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lct_pkg::ST_IDLE;
         cnt_ff      <= '0;
         occ_ff      <= '0;
         capacity_ff <= lct_pkg::CAP_RESET;
         thr_all_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         occ_ff     <= occ_in;
         thr_all_ff <= thr_all_in;
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      sel_ff <= sel_in;
      thr_ff <= thr_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy low after request transfer");

   a_single_response: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(ENTRIES))
      else $error("occupancy above table size");

   a_miss_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.hit |-> rsp_item.read_value == '0)
      else $error("miss response carries data");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      slot_we && do_insert && !table_full |-> occ_ff != OCC_W'(ENTRIES))
      else $error("insert into free slot while table is full");
`endif

endmodule

FILE: sv/lct_entry_ram.sv
// ----------------------------------------------------------------------------
// lct_entry_ram
// Entry storage: key, data, use count and recency rank memories with one
// registered read port, a slot write port and a separate rank write port.
// Valid bits are flip-flops cleared by reset.
// ----------------------------------------------------------------------------
module lct_entry_ram #(
   parameter int ENTRIES = lct_pkg::DEF_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
   output lct_pkg::slot_type                  rd_entry,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_rank,
   input  logic                               slot_we,
   input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] slot_addr,
   input  lct_pkg::slot_type                  slot_wr,
   input  logic                               rank_we,
   input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rank_addr,
   input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rank_wdata
);

   localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

   logic [ENTRIES-1:0]               valid_ff;
   logic [lct_pkg::KEY_W-1:0]        key_mem_ff   [ENTRIES];
   logic [lct_pkg::DATA_W-1:0]       data_mem_ff  [ENTRIES];
   logic [lct_pkg::COUNT_W-1:0]      count_mem_ff [ENTRIES];
   logic [IDX_W-1:0]                 rank_mem_ff  [ENTRIES];
   lct_pkg::slot_type                rd_entry_ff;
   logic [IDX_W-1:0]                 rd_rank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (slot_we) begin
         valid_ff[slot_addr] <= slot_wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         key_mem_ff[slot_addr]   <= slot_wr.key;
         data_mem_ff[slot_addr]  <= slot_wr.data;
         count_mem_ff[slot_addr] <= slot_wr.count;
      end
      if (rank_we) begin
         rank_mem_ff[rank_addr] <= rank_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry_ff.valid <= valid_ff[rd_addr];
      rd_entry_ff.key   <= key_mem_ff[rd_addr];
      rd_entry_ff.data  <= data_mem_ff[rd_addr];
      rd_entry_ff.count <= count_mem_ff[rd_addr];
      rd_rank_ff        <= rank_mem_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;
   assign rd_rank  = rd_rank_ff;

endmodule

FILE: sv/lct_scan.sv
// ----------------------------------------------------------------------------
// lct_scan
// Shared compare unit: takes one entry per step and keeps the running key
// match, the eviction victim (lowest count, then least recent) and the first
// free slot.
// ----------------------------------------------------------------------------
module lct_scan #(
   parameter int ENTRIES = lct_pkg::DEF_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  logic                               step,
   input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] idx,
   input  lct_pkg::slot_type                  entry,
   input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rank,
   input  logic [lct_pkg::KEY_W-1:0]          key,
   output logic                               found,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] match_idx,
   output logic [lct_pkg::DATA_W-1:0]         match_data,
   output logic [lct_pkg::COUNT_W-1:0]        match_count,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] match_rank,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] vic_idx,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] vic_rank,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] free_idx
);

   localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

   logic                         found_ff, found_in;
   logic                         have_ff, have_in;
   logic                         free_ff, free_in;
   logic [IDX_W-1:0]             match_idx_ff, match_idx_in;
   logic [lct_pkg::DATA_W-1:0]   match_data_ff, match_data_in;
   logic [lct_pkg::COUNT_W-1:0]  match_count_ff, match_count_in;
   logic [IDX_W-1:0]             match_rank_ff, match_rank_in;
   logic [IDX_W-1:0]             vic_idx_ff, vic_idx_in;
   logic [lct_pkg::COUNT_W-1:0]  vic_count_ff, vic_count_in;
   logic [IDX_W-1:0]             vic_rank_ff, vic_rank_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;
   logic                         take;

   always_comb begin
      found_in       = found_ff;
      have_in        = have_ff;
      free_in        = free_ff;
      match_idx_in   = match_idx_ff;
      match_data_in  = match_data_ff;
      match_count_in = match_count_ff;
      match_rank_in  = match_rank_ff;
      vic_idx_in     = vic_idx_ff;
      vic_count_in   = vic_count_ff;
      vic_rank_in    = vic_rank_ff;
      free_idx_in    = free_idx_ff;
      take = !have_ff || (entry.count < vic_count_ff) ||
             ((entry.count == vic_count_ff) && (rank > vic_rank_ff));
      if (clear) begin
         found_in = 1'b0;
         have_in  = 1'b0;
         free_in  = 1'b0;
      end else if (step) begin
         if (entry.valid && (entry.key == key) && !found_ff) begin
            found_in       = 1'b1;
            match_idx_in   = idx;
            match_data_in  = entry.data;
            match_count_in = entry.count;
            match_rank_in  = rank;
         end
         if (entry.valid && take) begin
            have_in      = 1'b1;
            vic_idx_in   = idx;
            vic_count_in = entry.count;
            vic_rank_in  = rank;
         end
         if (!entry.valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         have_ff  <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         found_ff <= found_in;
         have_ff  <= have_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff   <= match_idx_in;
      match_data_ff  <= match_data_in;
      match_count_ff <= match_count_in;
      match_rank_ff  <= match_rank_in;
      vic_idx_ff     <= vic_idx_in;
      vic_count_ff   <= vic_count_in;
      vic_rank_ff    <= vic_rank_in;
      free_idx_ff    <= free_idx_in;
   end

   assign found       = found_ff;
   assign match_idx   = match_idx_ff;
   assign match_data  = match_data_ff;
   assign match_count = match_count_ff;
   assign match_rank  = match_rank_ff;
   assign vic_idx     = vic_idx_ff;
   assign vic_rank    = vic_rank_ff;
   assign free_idx    = free_idx_ff;

endmodule
